### design/lrm_pkg.sv
`default_nettype none

package lrm_pkg;

    localparam int NUM_VOICES       = 3;
    localparam int FRAC_BITS        = 16;
    localparam int FRAMES_PER_VOICE = 65536;

    localparam int VOICE_W   = 2;
    localparam int FRAME_W   = 16;
    localparam int LEN_W     = 17;
    localparam int POS_W     = 33;
    localparam int MEM_AW    = VOICE_W + FRAME_W;
    localparam int MEM_DEPTH = NUM_VOICES * FRAMES_PER_VOICE;
    localparam int MEM_DW    = 32;

    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_C  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd7;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_MIX     = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRAP,
        ST_MOD_WAIT,
        ST_ADDR,
        ST_READ_NXT,
        ST_MUL_DL,
        ST_MUL_DR,
        ST_MUL_VL,
        ST_MUL_VR,
        ST_ACC_R,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

### design/lrm_mem.sv
`default_nettype none

module lrm_mem
    import lrm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [MEM_AW-1:0] i_waddr,
    input  wire logic [MEM_DW-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [MEM_AW-1:0] i_raddr,
    output logic      [MEM_DW-1:0] o_rdata
);

    logic [MEM_DW-1:0] r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/lrm_mod.sv
`default_nettype none

module lrm_mod
    import lrm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [LEN_W-1:0] i_dividend,
    input  wire logic [LEN_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [LEN_W-1:0] o_rem
);

    // Restoring remainder, one dividend bit per cycle.
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_dvd;
    logic [LEN_W-1:0] r_div;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[LEN_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = trial - {1'b0, r_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(LEN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem[LEN_W-1:0];
            r_dvd <= {r_dvd[LEN_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### design/looping_resampler_mixer_core.sv
`default_nettype none

// Looping sample playback mixer with linear interpolation.
// Input channel (i_in_valid / o_in_stall) carries one transaction per item.
// A load transaction writes one stereo frame into the voice memory, a restart
// transaction zeroes the three play positions, and a mix transaction reads
// every active, loaded voice, mixes it into the game sample and returns one
// output transaction on (o_out_valid / i_out_stall). Load and restart
// leave the input free. A mix handles the voices in turn: check, read two
// frames, interpolate, scale by volume, accumulate; then it applies the
// master gain to each side. A voice whose position has run past its end
// first waits for the loop wrap, a bit-serial remainder unit. All of this
// shares one multiplier and the single read port of the sample memory. The
// input stalls while a mix is in progress; the finished frame sits in an
// output register, so a new item can be accepted while it waits. If the
// receiver stalls when a second mix is done, the sequencer holds in its
// last step until the register frees. Synchronous reset clears positions,
// control state and the configuration registers (phase step one frame,
// master gain unity); the sample memory is not cleared and must be loaded before a voice is played.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.

module looping_resampler_mixer_core
    import lrm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_mode,
    input  wire logic [1:0]            i_track_select,
    input  wire logic [15:0]           i_load_address,
    input  wire logic signed [15:0]    i_load_left,
    input  wire logic signed [15:0]    i_load_right,
    input  wire logic signed [15:0]    i_game_left,
    input  wire logic signed [15:0]    i_game_right,
    input  wire logic [15:0]           i_volume_a,
    input  wire logic [15:0]           i_volume_b,
    input  wire logic [15:0]           i_volume_c,
    input  wire logic [2:0]            i_active_mask,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [15:0]         o_out_left,
    output logic signed [15:0]         o_out_right
);

    // Configuration registers.
    logic [LEN_W-1:0]   r_len_cfg  [NUM_VOICES];
    logic [FRAME_W-1:0] r_loop_cfg [NUM_VOICES];
    logic [17:0]        r_step;
    logic [15:0]        r_gain;

    // Per-voice play positions in 17.16 fixed point.
    logic [POS_W-1:0]   r_position [NUM_VOICES];

    // Sequencer state and the working registers of the current voice.
    t_state             r_state, n_state;
    logic [VOICE_W-1:0] r_v;
    logic [2:0]         r_mask;
    logic [15:0]        r_vol [NUM_VOICES];
    logic signed [15:0] r_game_l, r_game_r;
    logic [LEN_W-1:0]   r_len;
    logic [FRAME_W-1:0] r_ls;
    logic [POS_W-1:0]   r_pos;
    logic [FRAME_W-1:0] r_nxt;
    logic [MEM_DW-1:0]  r_s0;
    logic signed [MUL_A_W-1:0] r_il, r_ir;
    logic signed [PROD_W-1:0]  r_acc_l, r_acc_r;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [23:0]        r_el;

    logic               r_out_valid;
    logic signed [15:0] r_out_l, r_out_r;

    // Sequencer outputs.
    logic               in_acc;
    logic               out_free;
    logic               mem_we;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_raddr;
    logic [MEM_DW-1:0]  mem_rdata;
    logic               mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic               mod_start;
    logic               mod_done;
    logic [LEN_W-1:0]   mod_rem;

    // Voice set-up: clamp the length and fold short loops back to frame zero.
    logic [LEN_W-1:0]   len_eff;
    logic [FRAME_W-1:0] ls_eff;
    logic               voice_on;
    logic               last_voice;
    logic [LEN_W-1:0]   cur_inc;

    always_comb begin
        if (r_len_cfg[r_v] > LEN_W'(FRAMES_PER_VOICE)) begin
            len_eff = LEN_W'(FRAMES_PER_VOICE);
        end else begin
            len_eff = r_len_cfg[r_v];
        end
        if (len_eff <= LEN_W'(1) || {1'b0, r_loop_cfg[r_v]} >= len_eff - LEN_W'(1)) begin
            ls_eff = '0;
        end else begin
            ls_eff = r_loop_cfg[r_v];
        end
        voice_on   = r_mask[r_v] && (r_len_cfg[r_v] != '0);
        last_voice = (r_v == VOICE_W'(NUM_VOICES - 1));
        cur_inc    = {1'b0, r_pos[31:16]} + LEN_W'(1);
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Interpolation differences and rounding of the scaled sums.
    logic signed [16:0] diff_l, diff_r;
    logic signed [PROD_W-1:0] acc_l_b, acc_r_b, prod_b;
    logic signed [PROD_W-1:0] ml_full, mr_full, e_full;
    logic signed [24:0] sum_l, sum_r;
    logic signed [15:0] sat_l, sat_r;
    logic signed [23:0] er;

    always_comb begin
        diff_l  = 17'(signed'(mem_rdata[15:0]))  - 17'(signed'(r_s0[15:0]));
        diff_r  = 17'(signed'(mem_rdata[31:16])) - 17'(signed'(r_s0[31:16]));
        acc_l_b = r_acc_l + (r_acc_l < 0 ? PROD_W'(65535) : PROD_W'(0));
        acc_r_b = r_acc_r + (r_acc_r < 0 ? PROD_W'(65535) : PROD_W'(0));
        ml_full = acc_l_b >>> FRAC_BITS;
        mr_full = acc_r_b >>> FRAC_BITS;
        prod_b  = r_prod + (r_prod < 0 ? PROD_W'(536870911) : PROD_W'(0));
        e_full  = prod_b >>> 29;
        er      = e_full[23:0];
        sum_l   = 25'(r_game_l) + 25'(r_el);
        sum_r   = 25'(r_game_r) + 25'(er);
        if (sum_l > 25'sd32767) begin
            sat_l = 16'sh7FFF;
        end else if (sum_l < -25'sd32768) begin
            sat_l = -16'sh8000;
        end else begin
            sat_l = sum_l[15:0];
        end
        if (sum_r > 25'sd32767) begin
            sat_r = 16'sh7FFF;
        end else if (sum_r < -25'sd32768) begin
            sat_r = -16'sh8000;
        end else begin
            sat_r = sum_r[15:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MODE_MIX) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (voice_on) begin
                    n_state = ST_WRAP;
                end else if (last_voice) begin
                    n_state = ST_GAIN_L;
                end
            end
            ST_WRAP: begin
                if (r_pos[32:16] >= r_len) begin
                    n_state = ST_MOD_WAIT;
                end else begin
                    n_state = ST_ADDR;
                end
            end
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR:     n_state = ST_READ_NXT;
            ST_READ_NXT: n_state = ST_MUL_DL;
            ST_MUL_DL:   n_state = ST_MUL_DR;
            ST_MUL_DR:   n_state = ST_MUL_VL;
            ST_MUL_VL:   n_state = ST_MUL_VR;
            ST_MUL_VR:   n_state = ST_ACC_R;
            ST_ACC_R: begin
                if (last_voice) begin
                    n_state = ST_GAIN_L;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_GAIN_L: n_state = ST_GAIN_R;
            ST_GAIN_R: n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory port, shared multiplier operands, wrap unit.
    always_comb begin
        o_in_stall = 1'b1;
        mem_re     = 1'b0;
        mem_raddr  = {r_v, r_pos[31:16]};
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mod_start  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_WRAP: mod_start = (r_pos[32:16] >= r_len);
            ST_ADDR: mem_re = 1'b1;
            ST_READ_NXT: begin
                mem_re    = 1'b1;
                mem_raddr = {r_v, r_nxt};
            end
            ST_MUL_DL: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(diff_l);
                mul_b  = MUL_B_W'({2'b00, r_pos[15:0]});
            end
            ST_MUL_DR: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(diff_r);
                mul_b  = MUL_B_W'({2'b00, r_pos[15:0]});
            end
            ST_MUL_VL: begin
                mul_en = 1'b1;
                mul_a  = r_il;
                mul_b  = MUL_B_W'({2'b00, r_vol[r_v]});
            end
            ST_MUL_VR: begin
                mul_en = 1'b1;
                mul_a  = r_ir;
                mul_b  = MUL_B_W'({2'b00, r_vol[r_v]});
            end
            ST_GAIN_L: begin
                mul_en = 1'b1;
                mul_a  = ml_full[MUL_A_W-1:0];
                mul_b  = MUL_B_W'({2'b00, r_gain});
            end
            ST_GAIN_R: begin
                mul_en = 1'b1;
                mul_a  = mr_full[MUL_A_W-1:0];
                mul_b  = MUL_B_W'({2'b00, r_gain});
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign mem_we = in_acc && (i_mode == MODE_LOAD)
                 && (i_track_select < VOICE_W'(NUM_VOICES));

    lrm_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({i_track_select, i_load_address}),
        .i_wdata ({i_load_right, i_load_left}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lrm_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_pos[32:16] - r_len),
        .i_divisor  (r_len - {1'b0, r_ls}),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_len_cfg[i]  <= '0;
                r_loop_cfg[i] <= '0;
            end
            r_step <= 18'd65536;
            r_gain <= 16'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEN_A:  r_len_cfg[0]  <= i_cfg_data[LEN_W-1:0];
                REG_LEN_B:  r_len_cfg[1]  <= i_cfg_data[LEN_W-1:0];
                REG_LEN_C:  r_len_cfg[2]  <= i_cfg_data[LEN_W-1:0];
                REG_LOOP_A: r_loop_cfg[0] <= i_cfg_data[FRAME_W-1:0];
                REG_LOOP_B: r_loop_cfg[1] <= i_cfg_data[FRAME_W-1:0];
                REG_LOOP_C: r_loop_cfg[2] <= i_cfg_data[FRAME_W-1:0];
                REG_STEP:   r_step        <= i_cfg_data;
                REG_GAIN:   r_gain        <= i_cfg_data[15:0];
            endcase
        end
    end

    // Control state: sequencer, voice counter, positions, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_position[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // A finished mix refills the output register in the same cycle
            // that the previous transaction leaves it.
            if (r_state == ST_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && i_mode == MODE_RESTART) begin
                for (int i = 0; i < NUM_VOICES; i++) begin
                    r_position[i] <= '0;
                end
            end
            if (in_acc) begin
                r_v <= '0;
            end else if ((r_state == ST_CHECK && !voice_on) || r_state == ST_ACC_R) begin
                if (!last_voice) begin
                    r_v <= r_v + VOICE_W'(1);
                end
            end
            if (r_state == ST_ACC_R) begin
                r_position[r_v] <= r_pos + POS_W'(r_step);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (in_acc) begin
            r_mask   <= i_active_mask;
            r_vol[0] <= i_volume_a;
            r_vol[1] <= i_volume_b;
            r_vol[2] <= i_volume_c;
            r_game_l <= i_game_left;
            r_game_r <= i_game_right;
            r_acc_l  <= '0;
            r_acc_r  <= '0;
        end
        unique case (r_state)
            ST_CHECK: begin
                r_len <= len_eff;
                r_ls  <= ls_eff;
                r_pos <= r_position[r_v];
            end
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    r_pos <= {LEN_W'(r_ls) + mod_rem, r_pos[15:0]};
                end
            end
            ST_ADDR: begin
                if (cur_inc >= r_len) begin
                    r_nxt <= r_ls;
                end else begin
                    r_nxt <= cur_inc[FRAME_W-1:0];
                end
            end
            ST_READ_NXT: r_s0 <= mem_rdata;
            ST_MUL_DR: r_il <= (MUL_A_W'(signed'(r_s0[15:0])) <<< FRAC_BITS)
                             + r_prod[MUL_A_W-1:0];
            ST_MUL_VL: r_ir <= (MUL_A_W'(signed'(r_s0[31:16])) <<< FRAC_BITS)
                             + r_prod[MUL_A_W-1:0];
            ST_MUL_VR: r_acc_l <= r_acc_l + r_prod;
            ST_ACC_R:  r_acc_r <= r_acc_r + r_prod;
            ST_GAIN_R: r_el <= e_full[23:0];
            ST_FINISH: begin
                if (out_free) begin
                    r_out_l <= sat_l;
                    r_out_r <= sat_r;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

    // The voice counter never points past the last voice.
    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v <= VOICE_W'(NUM_VOICES - 1))
        else $error("voice counter out of range");

    // Once wrapped, the read frame lies inside the stored length.
    a_pos_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADDR |-> r_pos[32:16] < r_len)
        else $error("play position not wrapped before the read");

    // A new result appears only at the end of a mix.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("output transaction without a finished mix");

    // The wrap unit only finishes while the sequencer waits for it.
    a_mod_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == ST_MOD_WAIT)
        else $error("remainder result arrived outside the wrap step");

endmodule

`default_nettype wire
